// File: rtl/fbsl_pkg.sv
// Shared types, constants and helpers for the firing bitmap to sparse list block.
package fbsl_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned WPOS_W     = 5;
  localparam int unsigned PPOS_W     = 7;
  localparam int unsigned CPOS_W     = 10;
  localparam int unsigned NEURON_W   = WPOS_W + BIT_W;
  localparam int unsigned PCNT_W     = 8;
  localparam int unsigned WPP_W      = 6;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned OUT_DW     = 32;

  localparam logic [PCNT_W-1:0] MAX_PARTITIONS = 8'd128;
  localparam logic [WPP_W-1:0]  MAX_WORDS      = 6'd32;
  localparam logic [CPOS_W-1:0] CYCLE_LAST     = 10'd1023;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 8'd1;
  localparam logic [WPP_W-1:0]  WPP_RESET  = 6'd32;

  typedef enum logic {
    REG_PARTITION_COUNT     = 1'b0,
    REG_WORDS_PER_PARTITION = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [CPOS_W-1:0] cycle;
    logic [PPOS_W-1:0] part;
    logic [WPOS_W-1:0] word;
  } pos_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } pos_ctrl_t;

  typedef struct packed {
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] rest;
    logic                 last;
  } scan_res_t;

  // Zero acts as one, oversized values saturate at the maximum.
  function automatic logic [PCNT_W-1:0] clamp_pcnt(input logic [PCNT_W-1:0] v);
    logic [PCNT_W-1:0] r;
    r = v;
    if (v == '0) r = PCNT_W'(1);
    else if (v > MAX_PARTITIONS) r = MAX_PARTITIONS;
    return r;
  endfunction

  function automatic logic [WPP_W-1:0] clamp_wpp(input logic [WPP_W-1:0] v);
    logic [WPP_W-1:0] r;
    r = v;
    if (v == '0) r = WPP_W'(1);
    else if (v > MAX_WORDS) r = MAX_WORDS;
    return r;
  endfunction

endpackage

// File: rtl/fbsl_scan.sv
// Shared bit-scan unit: finds the lowest set bit of a word and clears it.
module fbsl_scan import fbsl_pkg::*; (
  input  logic [WORD_BITS-1:0] rem_i,
  output scan_res_t            res_o
);

  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] rest;
  logic [BIT_W-1:0]     idx;

  assign onehot = rem_i & (~rem_i + WORD_BITS'(1));
  assign rest   = rem_i & (rem_i - WORD_BITS'(1));

  // Encode the isolated bit: an OR over independent lanes.
  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) idx = idx | BIT_W'(i);
    end
  end

  assign res_o.bit_idx = idx;
  assign res_o.rest    = rest;
  assign res_o.last    = (rest == '0);

endmodule

// File: rtl/fbsl_pos.sv
// Word, partition and cycle position counters with configurable wrap limits.
module fbsl_pos import fbsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pos_ctrl_t         ctrl_i,
  input  logic [PCNT_W-1:0] partition_count_i,
  input  logic [WPP_W-1:0]  words_per_partition_i,
  output pos_t              pos_o
);

  pos_t              pos_q, pos_d;
  logic [WPP_W-1:0]  wlim;
  logic [PCNT_W-1:0] plim;
  logic [WPOS_W-1:0] w_inc;
  logic [PPOS_W-1:0] p_inc;

  assign wlim  = clamp_wpp(words_per_partition_i);
  assign plim  = clamp_pcnt(partition_count_i);
  assign w_inc = pos_q.word + WPOS_W'(1);
  assign p_inc = pos_q.part + PPOS_W'(1);

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      pos_d = '0;
    end else if (ctrl_i.advance) begin
      pos_d.word = w_inc;
      if (w_inc == '0 || {1'b0, w_inc} >= wlim) begin
        pos_d.word = '0;
        pos_d.part = p_inc;
        if (p_inc == '0 || {1'b0, p_inc} >= plim) begin
          pos_d.part = '0;
          // Saturate at the last cycle.
          if (pos_q.cycle != CYCLE_LAST) pos_d.cycle = pos_q.cycle + CPOS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// File: rtl/firing_bitmap_to_sparse_list.sv
// Top level: converts firing bitmap words into a stream of sparse firing records.
// A taken word is held in the sequencer; its records are registered at the output.
// Throughput: one record per cycle from the shared bit-scan unit while the output is free;
//   the input stays busy until a word's last set bit is emitted (an empty word does not hold it).
// Reset: rst_ni clears positions, output valid and the sequencer at once;
//   partition_count returns to 1 and words_per_partition to 32.
module firing_bitmap_to_sparse_list import fbsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] bitmap_word
  input  logic              s_axis_tlast,   // buffer_end
  // Output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [9:0] cycle_index, [16:10] partition_index,
                                            // [26:17] neuron_index, [31:27] zero
  output logic              m_axis_tlast,   // last_of_word
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PCNT_W-1:0] pcnt_q;
  logic [WPP_W-1:0]  wpp_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= PCNT_RESET;
      wpp_q  <= WPP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PARTITION_COUNT:     pcnt_q <= pwdata[PCNT_W-1:0];
        REG_WORDS_PER_PARTITION: wpp_q  <= pwdata[WPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PARTITION_COUNT:     prdata = {{(APB_DW-PCNT_W){1'b0}}, pcnt_q};
      REG_WORDS_PER_PARTITION: prdata = {{(APB_DW-WPP_W){1'b0}}, wpp_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Position counters: advance (or clear on buffer end) as each word is taken,
  // so the word's own positions are latched alongside its bitmap.
  // ---------------------------------------------------------------------------
  logic      in_acc;
  pos_ctrl_t pos_ctrl;
  pos_t      pos_cur;

  assign in_acc         = s_axis_tvalid && s_axis_tready;
  assign pos_ctrl.clear   = in_acc && s_axis_tlast;
  assign pos_ctrl.advance = in_acc && !s_axis_tlast;

  fbsl_pos u_pos (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctrl_i                (pos_ctrl),
    .partition_count_i     (pcnt_q),
    .words_per_partition_i (wpp_q),
    .pos_o                 (pos_cur)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: hold the remaining bits and peel off one per cycle through the
  // shared scan unit whenever the output register is free.
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  pos_t                 item_q;
  scan_res_t            scan;
  logic                 out_free;
  logic                 emit;

  fbsl_scan u_scan (
    .rem_i (rem_q),
    .res_o (scan)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rem_d = s_axis_tdata;
          // An empty word produces nothing; stay ready.
          if (s_axis_tdata != '0) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          emit  = 1'b1;
          rem_d = scan.rest;
          if (scan.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload of the word in flight.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (in_acc) item_q <= pos_cur;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                 m_valid_q;
  logic [CPOS_W-1:0]    o_cycle_q;
  logic [PPOS_W-1:0]    o_part_q;
  logic [NEURON_W-1:0]  o_neuron_q;
  logic                 o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_cycle_q  <= item_q.cycle;
      o_part_q   <= item_q.part;
      o_neuron_q <= {item_q.word, scan.bit_idx};
      o_last_q   <= scan.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DW-CPOS_W-PPOS_W-NEURON_W){1'b0}},
                          o_neuron_q, o_part_q, o_cycle_q};
  assign m_axis_tlast  = o_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The scan state never runs on an exhausted word.
  a_scan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> rem_q != '0)
    else $error("scan state with no bits left");

  // An empty word leaves the block ready for the next one.
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata == '0) |=> s_axis_tready)
    else $error("empty word stalled the input");

  // Emitting the last record of a word returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && scan.last) |=> (state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("last record did not close the word");

endmodule
